// ===== rtl/era_pkg.sv =====
// Shared types and codes for the extent region allocator.
`timescale 1ns / 1ps
package era_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MODE  = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_NO_FIT    = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic [2:0] MODE_LOW      = 3'd0;
  localparam logic [2:0] MODE_HIGH     = 3'd1;
  localparam logic [2:0] MODE_FIXED    = 3'd2;
  localparam logic [2:0] MODE_LOW_AL   = 3'd3;
  localparam logic [2:0] MODE_HIGH_AL  = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_LEN  = 1'b1;

  // Sizes and starts keep a 4-byte granule.
  localparam logic [31:0] GRAIN_MASK = 32'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_ARD, S_AEV, S_CARVE, S_URD, S_UEV, S_PCHK, S_PRD, S_PEV,
    S_MERGE, S_INS, S_INSW, S_REM, S_REMW, S_UWR, S_UCLR
  } era_state_t;

  // Free extent write data choices.
  typedef enum logic [2:0] {
    W_LB_S, W_E_UB, W_RD, W_INS, W_PREV_NE, W_PREV_UB, W_LB_NE
  } era_wsel_t;

  typedef struct packed {
    logic      load;
    logic      check;
    logic      take_hit;
    logic      take_used;
    logic      take_prev;
    logic      take_next;
    logic      fwe;
    era_wsel_t wsel;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      used_wr;
    logic      used_clr;
    logic      fin;
    logic [2:0] fin_status;
  } era_cmd_t;

  typedef struct packed {
    logic [2:0] pc_status;
    logic       is_free;
    logic       is_high;
    logic       fit;
    logic       left;
    logic       right;
    logic       match;
    logic       lt_ub;
    logic       mprev;
    logic       mnext;
    logic       out_busy;
  } era_stat_t;

endpackage

// ===== rtl/extent_region_allocator_core.sv =====
// Top level of the extent region allocator: sequencer plus datapath.
`timescale 1ns / 1ps
// One item at a time. An allocate scans the free extents one by one and,
// when an extent is split or removed, shifts the table entries after it;
// a free searches the used slots, walks the extents to the insertion point
// and shifts entries when one is inserted or removed. Every scan and shift
// goes through the free-extent memory with its registered read, one entry
// at a time. A region register write resets the tables. A result stays in
// the output register until taken; the next item is accepted once it has
// been taken.
module extent_region_allocator_core import era_pkg::*; #(
  parameter int FREE_SLOTS = 32,
  parameter int USED_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [2:0]  in_place_mode,
  input  logic [31:0] in_place_value,
  input  logic [31:0] in_request_bytes,
  input  logic [31:0] in_free_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_block_start,
  output logic [31:0] out_free_bytes
);

  localparam int FIW = $clog2(FREE_SLOTS);
  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int UIW = USED_SLOTS > 1 ? $clog2(USED_SLOTS) : 1;

  era_cmd_t       cmd;
  era_stat_t      st;
  logic [FCW-1:0] cnt;
  logic [FIW-1:0] faddr, fwaddr;
  logic [UIW-1:0] uaddr;

  era_ctrl #(.FREE_SLOTS(FREE_SLOTS), .USED_SLOTS(USED_SLOTS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cnt      (cnt),
    .cmd      (cmd),
    .faddr    (faddr),
    .fwaddr   (fwaddr),
    .uaddr    (uaddr)
  );

  era_dp #(.FREE_SLOTS(FREE_SLOTS), .USED_SLOTS(USED_SLOTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_command),
    .in_place_mode    (in_place_mode),
    .in_place_value   (in_place_value),
    .in_request_bytes (in_request_bytes),
    .in_free_start    (in_free_start),
    .cmd              (cmd),
    .faddr            (faddr),
    .fwaddr           (fwaddr),
    .uaddr            (uaddr),
    .st               (st),
    .cnt              (cnt),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_block_start  (out_block_start),
    .out_free_bytes   (out_free_bytes)
  );

endmodule

// ===== rtl/era_ctrl.sv =====
// Sequencer for allocate and free requests: scans, shifts and final updates.
`timescale 1ns / 1ps
module era_ctrl import era_pkg::*; #(
  parameter int FREE_SLOTS = 32,
  parameter int USED_SLOTS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  era_stat_t                   st,
  input  logic [$clog2(FREE_SLOTS+1)-1:0] cnt,
  output era_cmd_t                    cmd,
  output logic [$clog2(FREE_SLOTS)-1:0]   faddr,
  output logic [$clog2(FREE_SLOTS)-1:0]   fwaddr,
  output logic [(USED_SLOTS > 1 ? $clog2(USED_SLOTS) : 1)-1:0] uaddr
);

  localparam int FIW = $clog2(FREE_SLOTS);
  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int UIW = USED_SLOTS > 1 ? $clog2(USED_SLOTS) : 1;

  era_state_t     state_r, state_nxt;
  logic [FCW-1:0] idx_r, idx_nxt;
  logic [FCW-1:0] k_r, k_nxt;
  logic [FCW-1:0] pos_r, pos_nxt;
  logic [UIW-1:0] uidx_r, uidx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      k_r     <= '0;
      pos_r   <= '0;
      uidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
      pos_r   <= pos_nxt;
      uidx_r  <= uidx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    uidx_nxt  = uidx_r;
    cmd       = '0;
    cmd.wsel  = W_RD;
    cmd.fin_status = ST_OK;
    faddr     = idx_r[FIW-1:0];
    fwaddr    = idx_r[FIW-1:0];
    uaddr     = uidx_r;
    in_ready  = (state_r == S_IDLE) && !st.out_busy;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.is_free) begin
          uidx_nxt  = '0;
          state_nxt = S_URD;
        end else if (st.pc_status != ST_OK) begin
          cmd.fin = 1'b1;
          cmd.fin_status = st.pc_status;
          state_nxt = S_IDLE;
        end else if (cnt == '0) begin
          cmd.fin = 1'b1;
          cmd.fin_status = ST_NO_FIT;
          state_nxt = S_IDLE;
        end else begin
          cmd.check = 1'b1;
          idx_nxt   = st.is_high ? cnt - FCW'(1) : '0;
          state_nxt = S_ARD;
        end
      end
      S_ARD: state_nxt = S_AEV;
      S_AEV: begin
        if (st.fit) begin
          cmd.take_hit = 1'b1;
          state_nxt = S_CARVE;
        end else if (st.is_high) begin
          if (idx_r == '0) begin
            cmd.fin = 1'b1;
            cmd.fin_status = ST_NO_FIT;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - FCW'(1);
            state_nxt = S_ARD;
          end
        end else if (idx_r + FCW'(1) < cnt) begin
          idx_nxt   = idx_r + FCW'(1);
          state_nxt = S_ARD;
        end else begin
          cmd.fin = 1'b1;
          cmd.fin_status = ST_NO_FIT;
          state_nxt = S_IDLE;
        end
      end
      S_CARVE: begin
        if (st.left && st.right) begin
          if (cnt >= FCW'(FREE_SLOTS)) begin
            cmd.fin = 1'b1;
            cmd.fin_status = ST_FULL;
            state_nxt = S_IDLE;
          end else begin
            cmd.fwe  = 1'b1;
            cmd.wsel = W_LB_S;
            pos_nxt  = idx_r + FCW'(1);
            k_nxt    = cnt;
            state_nxt = S_INS;
          end
        end else if (st.left) begin
          cmd.fwe  = 1'b1;
          cmd.wsel = W_LB_S;
          state_nxt = S_UWR;
        end else if (st.right) begin
          cmd.fwe  = 1'b1;
          cmd.wsel = W_E_UB;
          state_nxt = S_UWR;
        end else begin
          k_nxt     = idx_r;
          state_nxt = S_REM;
        end
      end
      S_URD: state_nxt = S_UEV;
      S_UEV: begin
        if (st.match) begin
          cmd.take_used = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_PCHK;
        end else if (uidx_r == UIW'(USED_SLOTS - 1)) begin
          cmd.fin = 1'b1;
          cmd.fin_status = ST_NOT_FOUND;
          state_nxt = S_IDLE;
        end else begin
          uidx_nxt  = uidx_r + UIW'(1);
          state_nxt = S_URD;
        end
      end
      S_PCHK: state_nxt = (idx_r < cnt) ? S_PRD : S_MERGE;
      S_PRD:  state_nxt = S_PEV;
      S_PEV: begin
        if (st.lt_ub) begin
          cmd.take_prev = 1'b1;
          idx_nxt   = idx_r + FCW'(1);
          state_nxt = S_PCHK;
        end else begin
          cmd.take_next = 1'b1;
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        if (st.mprev && st.mnext) begin
          fwaddr   = FIW'(idx_r - FCW'(1));
          cmd.fwe  = 1'b1;
          cmd.wsel = W_PREV_NE;
          k_nxt    = idx_r;
          state_nxt = S_REM;
        end else if (st.mprev) begin
          fwaddr   = FIW'(idx_r - FCW'(1));
          cmd.fwe  = 1'b1;
          cmd.wsel = W_PREV_UB;
          state_nxt = S_UCLR;
        end else if (st.mnext) begin
          cmd.fwe  = 1'b1;
          cmd.wsel = W_LB_NE;
          state_nxt = S_UCLR;
        end else if (cnt >= FCW'(FREE_SLOTS)) begin
          cmd.fin = 1'b1;
          cmd.fin_status = ST_FULL;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt   = idx_r;
          k_nxt     = cnt;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if (k_r > pos_r) begin
          faddr     = FIW'(k_r - FCW'(1));
          state_nxt = S_INSW;
        end else begin
          fwaddr      = pos_r[FIW-1:0];
          cmd.fwe     = 1'b1;
          cmd.wsel    = W_INS;
          cmd.cnt_inc = 1'b1;
          state_nxt   = st.is_free ? S_UCLR : S_UWR;
        end
      end
      S_INSW: begin
        // shift one entry up
        fwaddr    = k_r[FIW-1:0];
        cmd.fwe   = 1'b1;
        cmd.wsel  = W_RD;
        k_nxt     = k_r - FCW'(1);
        state_nxt = S_INS;
      end
      S_REM: begin
        if (k_r + FCW'(1) < cnt) begin
          faddr     = FIW'(k_r + FCW'(1));
          state_nxt = S_REMW;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = st.is_free ? S_UCLR : S_UWR;
        end
      end
      S_REMW: begin
        fwaddr    = k_r[FIW-1:0];
        cmd.fwe   = 1'b1;
        cmd.wsel  = W_RD;
        k_nxt     = k_r + FCW'(1);
        state_nxt = S_REM;
      end
      S_UWR: begin
        cmd.used_wr = 1'b1;
        cmd.fin     = 1'b1;
        cmd.fin_status = ST_OK;
        state_nxt   = S_IDLE;
      end
      S_UCLR: begin
        cmd.used_clr = 1'b1;
        cmd.fin      = 1'b1;
        cmd.fin_status = ST_OK;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/era_dp.sv =====
// Datapath: extent and used-block memories, item registers, fit arithmetic, result.
`timescale 1ns / 1ps
module era_dp import era_pkg::*; #(
  parameter int FREE_SLOTS = 32,
  parameter int USED_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_command,
  input  logic [2:0]  in_place_mode,
  input  logic [31:0] in_place_value,
  input  logic [31:0] in_request_bytes,
  input  logic [31:0] in_free_start,
  input  era_cmd_t    cmd,
  input  logic [$clog2(FREE_SLOTS)-1:0] faddr,
  input  logic [$clog2(FREE_SLOTS)-1:0] fwaddr,
  input  logic [(USED_SLOTS > 1 ? $clog2(USED_SLOTS) : 1)-1:0] uaddr,
  output era_stat_t   st,
  output logic [$clog2(FREE_SLOTS+1)-1:0] cnt,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_block_start,
  output logic [31:0] out_free_bytes
);

  localparam int FIW = $clog2(FREE_SLOTS);
  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int UIW = USED_SLOTS > 1 ? $clog2(USED_SLOTS) : 1;

  logic [32:0] fe_s_mem [FREE_SLOTS];
  logic [32:0] fe_e_mem [FREE_SLOTS];
  logic [31:0] us_s_mem [USED_SLOTS];
  logic [32:0] us_l_mem [USED_SLOTS];

  logic [32:0] fe_rs_r, fe_re_r;
  logic [31:0] us_rs_r;
  logic [32:0] us_rl_r;

  logic [31:0] base_r, len_r;
  logic [31:0] fbc_r;
  logic [FCW-1:0] cnt_r;
  logic [USED_SLOTS-1:0] valid_r;

  logic        cmd_r;
  logic [2:0]  mode_r;
  logic [31:0] pval_r, req_r, fstart_r;
  logic [31:0] mask_r;
  logic [32:0] size_r;
  logic [UIW-1:0] slot_r;
  logic [32:0] s_r, lb_r, ub_r;
  logic [32:0] prev_s_r, prev_e_r, nxt_s_r, nxt_e_r;
  logic        prev_vld_r, nxt_vld_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_start_r, out_fb_r;

  // region init values
  logic [31:0] base_nxt, len_nxt;
  logic [32:0] rend;
  always_comb begin
    base_nxt = base_r;
    len_nxt  = len_r;
    unique case (cfg_index)
      CFG_BASE: base_nxt = cfg_wdata;
      CFG_LEN:  len_nxt  = cfg_wdata;
      default:  base_nxt = base_r;
    endcase
    rend = {1'b0, base_nxt} + {1'b0, len_nxt};
    if (rend[32]) rend = 33'h1_0000_0000;
  end

  // pre-checks of an allocate request
  logic        aligned, any_slot;
  logic [31:0] mask_c;
  logic [32:0] size_c;
  logic [UIW-1:0] slot_c;
  logic [2:0]  pc_status_c;
  always_comb begin
    aligned = (mode_r == MODE_LOW_AL) || (mode_r == MODE_HIGH_AL);
    mask_c  = aligned ? ((pval_r - 32'd1) | GRAIN_MASK) : GRAIN_MASK;
    size_c  = ({1'b0, req_r} + {1'b0, GRAIN_MASK}) & ~{1'b0, GRAIN_MASK};
    any_slot = 1'b0;
    slot_c   = '0;
    for (int i = USED_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        any_slot = 1'b1;
        slot_c   = UIW'(i);
      end
    end
    if (mode_r > MODE_HIGH_AL) pc_status_c = ST_BAD_MODE;
    else if (aligned && (pval_r == '0 || (pval_r & (pval_r - 32'd1)) != '0))
      pc_status_c = ST_BAD_MODE;
    else if (req_r > fbc_r) pc_status_c = ST_TOO_LARGE;
    else if (size_c == '0)  pc_status_c = ST_NO_FIT;
    else if (!any_slot)     pc_status_c = ST_FULL;
    else                    pc_status_c = ST_OK;
  end

  // fit of the extent just read
  logic [34:0] rs35, re35, sz35, mk35, low_a, hi_a, fx_a, hit_a;
  logic        low_fit, hi_fit, fx_fit, fit_c;
  always_comb begin
    rs35  = {2'b0, fe_rs_r};
    re35  = {2'b0, fe_re_r};
    sz35  = {2'b0, size_r};
    mk35  = {3'b0, mask_r};
    low_a = (rs35 + mk35) & ~mk35;
    low_fit = (low_a + sz35) <= re35;
    hi_a  = (re35 - sz35) & ~mk35;
    hi_fit = (re35 >= rs35 + sz35) && (hi_a >= rs35);
    fx_a  = {3'b0, pval_r & ~GRAIN_MASK};
    fx_fit = (rs35 <= fx_a) && (fx_a + sz35 <= re35);
    case (mode_r) inside
      MODE_HIGH, MODE_HIGH_AL: begin
        fit_c = hi_fit;
        hit_a = hi_a;
      end
      MODE_FIXED: begin
        fit_c = fx_fit;
        hit_a = fx_a;
      end
      default: begin
        fit_c = low_fit;
        hit_a = low_a;
      end
    endcase
  end

  logic [32:0] e_c;
  assign e_c          = s_r + size_r;
  assign st.pc_status = pc_status_c;
  assign st.fit       = fit_c;
  assign st.is_free   = (cmd_r == CMD_FREE);
  assign st.is_high   = (mode_r == MODE_HIGH) || (mode_r == MODE_HIGH_AL);
  assign st.left      = s_r > lb_r;
  assign st.right     = e_c < ub_r;
  assign st.match     = valid_r[uaddr] && ({1'b0, us_rs_r} == {1'b0, fstart_r});
  assign st.lt_ub     = fe_rs_r < ub_r;
  assign st.mprev     = prev_vld_r && (prev_e_r == lb_r);
  assign st.mnext     = nxt_vld_r && (nxt_s_r == ub_r);
  assign st.out_busy  = out_valid_r;
  assign cnt = cnt_r;

  // free extent write data
  logic [32:0] wd_s, wd_e;
  always_comb begin
    case (cmd.wsel)
      W_LB_S:    begin wd_s = lb_r;     wd_e = s_r;     end
      W_E_UB:    begin wd_s = e_c;      wd_e = ub_r;    end
      W_INS:     begin wd_s = st.is_free ? lb_r : e_c; wd_e = ub_r; end
      W_PREV_NE: begin wd_s = prev_s_r; wd_e = nxt_e_r; end
      W_PREV_UB: begin wd_s = prev_s_r; wd_e = ub_r;    end
      W_LB_NE:   begin wd_s = lb_r;     wd_e = nxt_e_r; end
      default:   begin wd_s = fe_rs_r;  wd_e = fe_re_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      fe_s_mem[0] <= {1'b0, base_nxt};
      fe_e_mem[0] <= rend;
    end else if (cmd.fwe) begin
      fe_s_mem[fwaddr] <= wd_s;
      fe_e_mem[fwaddr] <= wd_e;
    end
    fe_rs_r <= fe_s_mem[faddr];
    fe_re_r <= fe_e_mem[faddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.used_wr) begin
      us_s_mem[slot_r] <= s_r[31:0];
      us_l_mem[slot_r] <= size_r;
    end
    us_rs_r <= us_s_mem[uaddr];
    us_rl_r <= us_l_mem[uaddr];
  end

  logic [31:0] fbc_nxt;
  always_comb begin
    fbc_nxt = fbc_r;
    if (cmd.used_wr)       fbc_nxt = fbc_r - size_r[31:0];
    else if (cmd.used_clr) fbc_nxt = fbc_r + size_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      len_r       <= '0;
      fbc_r       <= '0;
      cnt_r       <= '0;
      valid_r     <= '0;
      prev_vld_r  <= 1'b0;
      nxt_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r  <= base_nxt;
        len_r   <= len_nxt;
        fbc_r   <= 32'(rend - {1'b0, base_nxt});
        cnt_r   <= (rend > {1'b0, base_nxt}) ? FCW'(1) : '0;
        valid_r <= '0;
      end else begin
        fbc_r <= fbc_nxt;
        if (cmd.cnt_inc) cnt_r <= cnt_r + FCW'(1);
        else if (cmd.cnt_dec) cnt_r <= cnt_r - FCW'(1);
        if (cmd.used_wr)  valid_r[slot_r] <= 1'b1;
        if (cmd.used_clr) valid_r[slot_r] <= 1'b0;
      end
      if (cmd.load) begin
        prev_vld_r <= 1'b0;
        nxt_vld_r  <= 1'b0;
      end else begin
        if (cmd.take_prev) prev_vld_r <= 1'b1;
        if (cmd.take_next) nxt_vld_r  <= 1'b1;
      end
      if (cmd.fin) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_command;
      mode_r   <= in_place_mode;
      pval_r   <= in_place_value;
      req_r    <= in_request_bytes;
      fstart_r <= in_free_start;
    end
    if (cmd.check) begin
      mask_r <= mask_c;
      size_r <= size_c;
      slot_r <= slot_c;
    end
    if (cmd.take_hit) begin
      s_r  <= {1'b0, hit_a[31:0]};
      lb_r <= fe_rs_r;
      ub_r <= fe_re_r;
    end
    if (cmd.take_used) begin
      slot_r <= uaddr;
      lb_r   <= {1'b0, us_rs_r};
      ub_r   <= {1'b0, us_rs_r} + us_rl_r;
      size_r <= us_rl_r;
    end
    if (cmd.take_prev) begin
      prev_s_r <= fe_rs_r;
      prev_e_r <= fe_re_r;
    end
    if (cmd.take_next) begin
      nxt_s_r <= fe_rs_r;
      nxt_e_r <= fe_re_r;
    end
    if (cmd.fin) begin
      out_status_r <= cmd.fin_status;
      out_start_r  <= (cmd.fin_status == ST_OK && cmd_r == CMD_ALLOC) ? s_r[31:0] : '0;
      out_fb_r     <= fbc_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_start = out_start_r;
  assign out_free_bytes  = out_fb_r;

endmodule

// ===== dv/tb_extent_region_allocator_core.sv =====
// Self-checking testbench for the extent region allocator: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_extent_region_allocator_core;
  import era_pkg::*;

  localparam int NFREE = 32;
  localparam int NUSED = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic [34:0] addr_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] block_start;
    logic [31:0] free_bytes;
  } alloc_result_t;

  typedef struct {
    logic        cmd;
    logic [2:0]  mode;
    logic [31:0] pval;
    logic [31:0] req;
    logic [31:0] fstart;
    bit          typed;
    logic [2:0]  st;
    logic [31:0] bs;
    logic [31:0] fb;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_BASE;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = CMD_ALLOC;
  logic [2:0]  in_place_mode = MODE_LOW;
  logic [31:0] in_place_value = '0;
  logic [31:0] in_request_bytes = '0;
  logic [31:0] in_free_start = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_block_start;
  logic [31:0] out_free_bytes;

  extent_region_allocator_core #(.FREE_SLOTS(NFREE), .USED_SLOTS(NUSED)) dut (.*);

  always #5 clk = ~clk;

  // Predicted allocator state.
  logic [31:0] reg_base, reg_len;
  addr_t ext_lo[NFREE], ext_hi[NFREE];
  int    ext_cnt;
  addr_t blk_lo[NUSED], blk_len[NUSED];
  bit    blk_live[NUSED];
  addr_t free_total;

  alloc_result_t pending_results[$];
  int  errors = 0;
  bit  idle_on = 1'b1;
  int  out_stall = 0;
  int  quiet_cycles = 0;

  function automatic void region_reset();
    addr_t top;
    top = addr_t'(reg_base) + addr_t'(reg_len);
    if (top > 35'h1_0000_0000) top = 35'h1_0000_0000;
    ext_lo[0] = addr_t'(reg_base);
    ext_hi[0] = top;
    ext_cnt = (top > addr_t'(reg_base)) ? 1 : 0;
    free_total = top - addr_t'(reg_base);
    for (int i = 0; i < NUSED; i++) begin
      blk_lo[i] = '0;
      blk_len[i] = '0;
      blk_live[i] = 1'b0;
    end
  endfunction

  function automatic void ext_insert(int pos, addr_t lo, addr_t hi);
    for (int k = ext_cnt; k > pos; k--) begin
      ext_lo[k] = ext_lo[k-1];
      ext_hi[k] = ext_hi[k-1];
    end
    ext_lo[pos] = lo;
    ext_hi[pos] = hi;
    ext_cnt++;
  endfunction

  function automatic void ext_remove(int pos);
    for (int k = pos; k + 1 < ext_cnt; k++) begin
      ext_lo[k] = ext_lo[k+1];
      ext_hi[k] = ext_hi[k+1];
    end
    ext_cnt--;
  endfunction

  function automatic logic [2:0] place_block(logic [2:0] mode, logic [31:0] pval,
                                             logic [31:0] req, output logic [31:0] at);
    addr_t mask, size, s, a, lb, ub;
    int slot, hit;
    bit found, left, right;
    mask = 35'd3;
    s = '0;
    slot = NUSED;
    hit = NFREE;
    found = 1'b0;
    at = '0;
    if (mode > MODE_HIGH_AL) return ST_BAD_MODE;
    if (mode == MODE_LOW_AL || mode == MODE_HIGH_AL) begin
      if (pval == 0 || (pval & (pval - 32'd1)) != 0) return ST_BAD_MODE;
      mask = (addr_t'(pval) - 35'd1) | 35'd3;
    end
    if (addr_t'(req) > free_total) return ST_TOO_LARGE;
    size = (addr_t'(req) + 35'd3) & ~35'd3;
    if (size == 0) return ST_NO_FIT;
    for (int k = 0; k < NUSED; k++)
      if (!blk_live[k]) begin
        slot = k;
        break;
      end
    if (slot >= NUSED) return ST_FULL;
    if (mode == MODE_LOW || mode == MODE_LOW_AL) begin
      for (int i = 0; i < ext_cnt && !found; i++) begin
        a = (ext_lo[i] + mask) & ~mask;
        if (a + size <= ext_hi[i]) begin
          s = a; hit = i; found = 1'b1;
        end
      end
    end else if (mode == MODE_HIGH || mode == MODE_HIGH_AL) begin
      for (int i = ext_cnt; i > 0 && !found; i--) begin
        lb = ext_lo[i-1];
        ub = ext_hi[i-1];
        if (ub >= lb + size) begin
          a = (ub - size) & ~mask;
          if (a >= lb) begin
            s = a; hit = i - 1; found = 1'b1;
          end
        end
      end
    end else begin
      a = addr_t'(pval) & ~35'd3;
      for (int i = 0; i < ext_cnt && !found; i++)
        if (ext_lo[i] <= a && a + size <= ext_hi[i]) begin
          s = a; hit = i; found = 1'b1;
        end
    end
    if (!found) return ST_NO_FIT;
    lb = ext_lo[hit];
    ub = ext_hi[hit];
    left = s > lb;
    right = s + size < ub;
    if (left && right) begin
      if (ext_cnt >= NFREE) return ST_FULL;
      ext_hi[hit] = s;
      ext_insert(hit + 1, s + size, ub);
    end else if (left) begin
      ext_hi[hit] = s;
    end else if (right) begin
      ext_lo[hit] = s + size;
    end else begin
      ext_remove(hit);
    end
    blk_lo[slot] = s;
    blk_len[slot] = size;
    blk_live[slot] = 1'b1;
    free_total -= size;
    at = s[31:0];
    return ST_OK;
  endfunction

  function automatic logic [2:0] return_block(logic [31:0] addr);
    int slot, p;
    addr_t lb, ub;
    bit mp, mn;
    slot = NUSED;
    p = 0;
    for (int k = 0; k < NUSED; k++)
      if (blk_live[k] && blk_lo[k] == addr_t'(addr)) begin
        slot = k;
        break;
      end
    if (slot >= NUSED) return ST_NOT_FOUND;
    lb = blk_lo[slot];
    ub = lb + blk_len[slot];
    while (p < ext_cnt && ext_lo[p] < ub) p++;
    mp = p > 0 && ext_hi[p-1] == lb;
    mn = p < ext_cnt && ext_lo[p] == ub;
    if (mp && mn) begin
      ext_hi[p-1] = ext_hi[p];
      ext_remove(p);
    end else if (mp) begin
      ext_hi[p-1] = ub;
    end else if (mn) begin
      ext_lo[p] = lb;
    end else begin
      if (ext_cnt >= NFREE) return ST_FULL;
      ext_insert(p, lb, ub);
    end
    blk_live[slot] = 1'b0;
    free_total += blk_len[slot];
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_result(stim_row_t r);
    alloc_result_t res;
    logic [31:0] at;
    at = '0;
    if (r.cmd == CMD_ALLOC) res.status = place_block(r.mode, r.pval, r.req, at);
    else res.status = return_block(r.fstart);
    res.block_start = (res.status == ST_OK) ? at : 32'd0;
    res.free_bytes = free_total[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result status", 32'(out_status), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_block_start !== want.block_start)
          report_mismatch("block_start", out_block_start, want.block_start);
        if (out_free_bytes !== want.free_bytes)
          report_mismatch("free_bytes", out_free_bytes, want.free_bytes);
      end
      out_stall = idle_on ? $urandom_range(0, 7) : 0;
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("extent_region_allocator_core regression: fail");
      $finish;
    end
  end

  task automatic send_item(stim_row_t r);
    int gap;
    alloc_result_t res;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= r.cmd;
    in_place_mode <= r.mode;
    in_place_value <= r.pval;
    in_request_bytes <= r.req;
    in_free_start <= r.fstart;
    do @(posedge clk); while (!in_ready);
    res = predict_result(r);
    if (r.typed) begin
      res.status = r.st;
      res.block_start = r.bs;
      res.free_bytes = r.fb;
    end
    pending_results.push_back(res);
  endtask

  task automatic drain_results();
    // drop valid so the last item is not taken twice
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_region(logic [31:0] base, logic [31:0] len);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_wdata <= base;
    @(negedge clk);
    cfg_index <= CFG_LEN;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_base = base;
    reg_len = len;
    region_reset();
  endtask

  function automatic stim_row_t random_row();
    stim_row_t r;
    int k, n, roll;
    r = '{default: '0};
    roll = $urandom_range(0, 99);
    n = 0;
    for (int i = 0; i < NUSED; i++) n += blk_live[i];
    if (roll < 40 && n > 0) begin
      // free a live block, now and then at a start offset by 4
      r.cmd = CMD_FREE;
      k = $urandom_range(0, n - 1);
      for (int i = 0; i < NUSED; i++)
        if (blk_live[i]) begin
          if (k == 0) r.fstart = blk_lo[i][31:0];
          k--;
        end
      if ($urandom_range(0, 9) == 0) r.fstart += 4;
    end else if (roll < 48) begin
      r.cmd = CMD_FREE;
      r.fstart = $urandom();
    end else begin
      r.cmd = CMD_ALLOC;
      r.mode = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      r.req = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 64);
      if (r.mode == MODE_FIXED) begin
        if (ext_cnt > 0 && $urandom_range(0, 3) != 0)
          r.pval = ext_lo[$urandom_range(0, ext_cnt - 1)][31:0] + $urandom_range(0, 64);
        else
          r.pval = $urandom();
      end else if ($urandom_range(0, 9) == 0) begin
        r.pval = $urandom();
      end else begin
        r.pval = 32'd1 << (($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                         : $urandom_range(0, 7));
      end
      if (r.mode != MODE_FIXED && r.mode != MODE_LOW_AL && r.mode != MODE_HIGH_AL &&
          $urandom_range(0, 1)) r.pval = $urandom();
    end
    if (r.cmd == CMD_ALLOC && $urandom_range(0, 3) == 0) r.fstart = $urandom();
    return r;
  endfunction

  stim_row_t directed[$];
  logic [31:0] phase_base[6] = '{32'h0000_1000, 32'hFFFF_FE00, 32'h0, 32'h0,
                                 32'hFFFF_FFFC, 32'h0000_0040};
  logic [31:0] phase_len[6]  = '{32'h200, 32'h400, 32'hFFFF_FFFF, 32'h0, 32'h4, 32'h100};
  int          phase_items[6] = '{400, 150, 150, 50, 50, 300};

  initial begin
    reg_base = '0;
    reg_len = '0;
    region_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    //            cmd        mode          pval            req            fstart   typed status bs fb
    directed = '{
      '{CMD_ALLOC, 3'd5,        32'h0,          32'd4,         32'h0,    1, ST_BAD_MODE,  0, 32'h100},
      '{CMD_ALLOC, 3'd7,        32'hFFFF_FFFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_BAD_MODE, 0,
        32'h100},
      '{CMD_ALLOC, MODE_LOW_AL, 32'h0,          32'd4,         32'h0,    1, ST_BAD_MODE,  0, 32'h100},
      '{CMD_ALLOC, MODE_HIGH_AL, 32'h6,         32'd4,         32'h0,    1, ST_BAD_MODE,  0, 32'h100},
      '{CMD_ALLOC, MODE_LOW,    32'h0,          32'hFFFF_FFFF, 32'h0,    1, ST_TOO_LARGE, 0, 32'h100},
      '{CMD_ALLOC, MODE_LOW,    32'h0,          32'd0,         32'h0,    1, ST_NO_FIT,    0, 32'h100},
      '{CMD_FREE,  MODE_LOW,    32'h0,          32'd0,         32'h1234, 1, ST_NOT_FOUND, 0, 32'h100},
      '{CMD_ALLOC, MODE_LOW,    32'h0,          32'd13,        32'h0,    1, ST_OK, 32'h1000, 32'hF0},
      '{CMD_ALLOC, MODE_HIGH,   32'h0,          32'd16,        32'h0,    1, ST_OK, 32'h10F0, 32'hE0},
      '{CMD_ALLOC, MODE_FIXED,  32'h1083,       32'd4,         32'h0,    1, ST_OK, 32'h1080, 32'hDC},
      '{CMD_ALLOC, MODE_FIXED,  32'h0,          32'd4,         32'h0,    1, ST_NO_FIT,    0, 32'hDC},
      '{CMD_ALLOC, MODE_LOW_AL, 32'h40,         32'd4,         32'h0,    1, ST_OK, 32'h1040, 32'hD8},
      '{CMD_ALLOC, MODE_HIGH_AL, 32'h20,        32'd8,         32'h0,    0, 0, 0, 0},
      '{CMD_ALLOC, MODE_LOW_AL, 32'h8000_0000,  32'd4,         32'h0,    1, ST_NO_FIT,    0, 32'hD0},
      '{CMD_ALLOC, MODE_HIGH_AL, 32'h1,         32'd4,         32'h0,    0, 0, 0, 0},
      '{CMD_FREE,  MODE_LOW,    32'h0,          32'd0,         32'h1000, 0, 0, 0, 0},
      '{CMD_FREE,  MODE_LOW,    32'h0,          32'd0,         32'h1080, 0, 0, 0, 0},
      '{CMD_FREE,  MODE_LOW,    32'h0,          32'd0,         32'h1040, 0, 0, 0, 0},
      '{CMD_FREE,  MODE_LOW,    32'h0,          32'd0,         32'h1000, 0, 0, 0, 0},
      '{CMD_ALLOC, MODE_FIXED,  32'hFFFF_FFFF,  32'h7FFF_FFFF, 32'h0,    0, 0, 0, 0},
      '{CMD_ALLOC, MODE_LOW,    32'h0,          32'hD8,        32'h0,    0, 0, 0, 0},
      '{CMD_ALLOC, MODE_HIGH,   32'h0,          32'd1,         32'h0,    0, 0, 0, 0}
    };

    set_region(32'h1000, 32'h100);
    foreach (directed[i]) send_item(directed[i]);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      idle_on = (ph != 2);
      set_region(phase_base[ph], phase_len[ph]);
      for (int n = 0; n < phase_items[ph]; n++) begin
        // halfway through, hold until the block has answered everything
        if (n == phase_items[ph] / 2) drain_results();
        send_item(random_row());
      end
      drain_results();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("extent_region_allocator_core regression: pass");
    end else begin
      $display("extent_region_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
